### rtl/link_quality_monitor_top_assert.svh
// Assertion macros for the link quality monitor.
// Each macro is empty when SYNTH is defined.
`ifndef LINK_QUALITY_MONITOR_TOP_ASSERT_SVH
`define LINK_QUALITY_MONITOR_TOP_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LQM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LQM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/lqm_pkg.sv
package lqm_pkg;

  // Default sizes of the loss window and the sample counter.
  localparam int unsigned LQM_LOSS_WINDOW       = 60;
  localparam int unsigned LQM_SAMPLE_COUNT_BITS = 20;

  // Fixed field and accumulator widths.
  localparam int unsigned LAT_W      = 16;
  localparam int unsigned LOSS_W     = 14;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned LOSS_SUM_W = 34;
  localparam int unsigned KIND_W     = 2;

  // Loss is reported in hundredths of a percent.
  localparam int unsigned LOSS_SCALE = 10000;
  localparam logic [LOSS_W-1:0] LOSS_MAX = 14'd10000;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_SPIKE_HIGH = 1'b0;
  localparam logic REG_SPIKE_LOW  = 1'b1;
  localparam logic [LAT_W-1:0] SPIKE_HIGH_RST = 16'd1200;
  localparam logic [LAT_W-1:0] SPIKE_LOW_RST  = 16'd800;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } lqm_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WINDOW,
    ST_LOSS,
    ST_TICK,
    ST_AVG_LAT,
    ST_AVG_JIT,
    ST_AVG_LOSS,
    ST_RESULT
  } lqm_state_e;

  typedef enum logic [1:0] {
    DIV_LOSS,
    DIV_LAT,
    DIV_JIT,
    DIV_LSUM
  } lqm_div_sel_e;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } lqm_div_sts_t;

endpackage

### rtl/lqm_div.sv
module lqm_div #(
  parameter int unsigned DVD_W = 36,
  parameter int unsigned DVS_W = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_W-1:0]     dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  output logic [DVD_W-1:0]     quotient_o,
  output lqm_pkg::lqm_div_sts_t sts_o
);
  import lqm_pkg::*;

  // Restoring division, one quotient bit per cycle.
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[DVS_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W:0] : rem_sh;
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

### rtl/link_quality_monitor_top.sv
// Channel   | Direction | Handshake               | Item
// ----------+-----------+-------------------------+---------------------------------------
// input     | in        | in_valid_i / in_ready_o | kind, ping_ok, latency, jitter
// result    | out       | out_valid_o/out_ready_i | latency, loss, spike, session averages
// config    | in        | APB psel/penable/pready | spike_high at 0x0, spike_low at 0x4
//
// A tick item has its result after a window read, a window update, a pass of the shared
// restoring divider for the loss and an update. A session end runs three divider passes
// for the means; a session start or an item of unknown kind goes straight to its result.
// The next item is taken once the sequencer is back in idle.
// Reset clears the control, window and session state; the window memory needs no clearing pass.
// A waiting result holds up the block only once the next item's result is ready too.

`include "link_quality_monitor_top_assert.svh"

module link_quality_monitor_top #(
  parameter int unsigned LOSS_WINDOW       = lqm_pkg::LQM_LOSS_WINDOW,
  parameter int unsigned SAMPLE_COUNT_BITS = lqm_pkg::LQM_SAMPLE_COUNT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lqm_pkg::KIND_W-1:0]      kind_i,
  input  logic                            ping_ok_i,
  input  logic [lqm_pkg::LAT_W-1:0]       latency_i,
  input  logic [lqm_pkg::LAT_W-1:0]       jitter_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            latency_valid_o,
  output logic [lqm_pkg::LAT_W-1:0]       latency_out_o,
  output logic [lqm_pkg::LOSS_W-1:0]      loss_level_o,
  output logic                            spike_alert_o,
  output logic                            spike_on_o,
  output logic                            in_session_o,
  output logic                            session_done_o,
  output logic [lqm_pkg::LAT_W-1:0]       avg_latency_o,
  output logic [lqm_pkg::LAT_W-1:0]       avg_jitter_o,
  output logic [lqm_pkg::LOSS_W-1:0]      avg_loss_o,
  output logic [lqm_pkg::LAT_W-1:0]       session_peak_o,
  output logic [lqm_pkg::LAT_W-1:0]       overall_peak_o,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lqm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lqm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lqm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lqm_pkg::*;

  // Window fill and loss total count up to the window size itself.
  localparam int unsigned WIN_W      = $clog2(LOSS_WINDOW + 1);
  localparam int unsigned POS_W      = (LOSS_WINDOW > 1) ? $clog2(LOSS_WINDOW) : 1;
  localparam int unsigned CNT_W      = SAMPLE_COUNT_BITS;
  localparam int unsigned DVS_W      = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int unsigned LOSS_NUM_W = WIN_W + LOSS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase; the port never
  // inserts wait states.
  // ---------------------------------------------------------------------------
  logic [LAT_W-1:0] spike_high_q;
  logic [LAT_W-1:0] spike_low_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_high_q <= SPIKE_HIGH_RST;
      spike_low_q  <= SPIKE_LOW_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SPIKE_HIGH: spike_high_q <= pwdata[LAT_W-1:0];
        REG_SPIKE_LOW:  spike_low_q  <= pwdata[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SPIKE_HIGH: prdata = APB_DATA_W'(spike_high_q);
      REG_SPIKE_LOW:  prdata = APB_DATA_W'(spike_low_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  lqm_state_e   state_q, state_d;
  lqm_div_sel_e div_sel;
  lqm_div_sts_t div_sts;
  logic         in_acc;
  logic         out_valid_q;
  logic         out_free;
  logic         mem_we, win_upd, div_start, loss_ld, tick_upd;
  logic         sess_start, avg_lat_ld, avg_jit_ld, avg_loss_ld, out_ld;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            KIND_TICK: state_d = ST_READ;
            KIND_END:  state_d = ST_AVG_LAT;
            default:   state_d = ST_RESULT;
          endcase
        end
      end
      ST_READ:     state_d = ST_WINDOW;
      ST_WINDOW:   state_d = ST_LOSS;
      ST_LOSS:     if (div_sts.done) state_d = ST_TICK;
      ST_TICK:     state_d = ST_RESULT;
      ST_AVG_LAT:  if (div_sts.done) state_d = ST_AVG_JIT;
      ST_AVG_JIT:  if (div_sts.done) state_d = ST_AVG_LOSS;
      ST_AVG_LOSS: if (div_sts.done) state_d = ST_RESULT;
      ST_RESULT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    win_upd     = 1'b0;
    div_start   = 1'b0;
    div_sel     = DIV_LOSS;
    loss_ld     = 1'b0;
    tick_upd    = 1'b0;
    sess_start  = 1'b0;
    avg_lat_ld  = 1'b0;
    avg_jit_ld  = 1'b0;
    avg_loss_ld = 1'b0;
    out_ld      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // A session end starts its first mean right away.
        if (in_valid_i && kind_i == KIND_END) begin
          div_start = 1'b1;
          div_sel   = DIV_LAT;
        end
        if (in_valid_i && kind_i == KIND_START) begin
          sess_start = 1'b1;
        end
      end
      ST_READ: mem_we = 1'b1;
      ST_WINDOW: begin
        win_upd   = 1'b1;
        div_start = 1'b1;
        div_sel   = DIV_LOSS;
      end
      ST_LOSS: loss_ld = div_sts.done;
      ST_TICK: tick_upd = 1'b1;
      ST_AVG_LAT: begin
        if (div_sts.done) begin
          avg_lat_ld = 1'b1;
          div_start  = 1'b1;
          div_sel    = DIV_JIT;
        end
      end
      ST_AVG_JIT: begin
        if (div_sts.done) begin
          avg_jit_ld = 1'b1;
          div_start  = 1'b1;
          div_sel    = DIV_LSUM;
        end
      end
      ST_AVG_LOSS: avg_loss_ld = div_sts.done;
      ST_RESULT:   out_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The accepted item is held for the whole computation.
  logic [KIND_W-1:0] kind_q;
  logic              ok_q;
  logic [LAT_W-1:0]  lat_q;
  logic [LAT_W-1:0]  jit_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      ok_q   <= ping_ok_i;
      lat_q  <= latency_i;
      jit_q  <= jitter_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Loss window. The memory holds one loss bit per tick. It is never cleared:
  // an old bit is only read back once the window is full, and by then every
  // entry has been written since reset.
  // ---------------------------------------------------------------------------
  logic             loss_mem [LOSS_WINDOW];
  logic             rd_bit_q;
  logic [POS_W-1:0] win_pos_q;
  logic [WIN_W-1:0] win_fill_q, win_fill_d;
  logic [WIN_W-1:0] win_total_q, win_total_d;
  logic             win_full;
  logic             new_bit;

  assign new_bit  = ~ok_q;
  assign win_full = (win_fill_q >= WIN_W'(LOSS_WINDOW));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      loss_mem[win_pos_q] <= new_bit;
      rd_bit_q            <= loss_mem[win_pos_q];
    end
  end

  always_comb begin
    if (win_full) begin
      win_fill_d  = win_fill_q;
      win_total_d = win_total_q - WIN_W'(rd_bit_q) + WIN_W'(new_bit);
    end else begin
      win_fill_d  = win_fill_q + 1'b1;
      win_total_d = win_total_q + WIN_W'(new_bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_pos_q   <= '0;
      win_fill_q  <= '0;
      win_total_q <= '0;
    end else if (win_upd) begin
      win_fill_q  <= win_fill_d;
      win_total_q <= win_total_d;
      if (win_pos_q == POS_W'(LOSS_WINDOW - 1)) begin
        win_pos_q <= '0;
      end else begin
        win_pos_q <= win_pos_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider. It computes the windowed loss on a tick, and the three
  // session means, one after another, on a session end.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]      lat_sum_q, jit_sum_q;
  logic [LOSS_SUM_W-1:0] loss_sum_q;
  logic [CNT_W-1:0]      count_q;
  logic [LOSS_NUM_W-1:0] loss_num;
  logic [SUM_W-1:0]      div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  logic [SUM_W-1:0]      quotient;

  assign loss_num = LOSS_NUM_W'(win_total_d) * LOSS_NUM_W'(LOSS_SCALE);

  always_comb begin
    case (div_sel)
      DIV_LAT: begin
        div_dividend = lat_sum_q;
        div_divisor  = DVS_W'(count_q);
      end
      DIV_JIT: begin
        div_dividend = jit_sum_q;
        div_divisor  = DVS_W'(count_q);
      end
      DIV_LSUM: begin
        div_dividend = SUM_W'(loss_sum_q);
        div_divisor  = DVS_W'(count_q);
      end
      default: begin
        div_dividend = SUM_W'(loss_num);
        div_divisor  = DVS_W'(win_fill_d);
      end
    endcase
  end

  lqm_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quotient),
    .sts_o      (div_sts)
  );

  // ---------------------------------------------------------------------------
  // Session state, accumulators, spike detector and peaks.
  // ---------------------------------------------------------------------------
  logic [LOSS_W-1:0]     loss_q;
  logic                  session_q, spike_q, alert_q;
  logic [LAT_W-1:0]      peak_sess_q, peak_all_q;
  logic                  acc_en;
  logic [SUM_W:0]        lat_sum_ext, jit_sum_ext;
  logic [LOSS_SUM_W:0]   loss_sum_ext;
  logic                  no_samples;
  logic [LAT_W-1:0]      q_sat16;
  logic [LOSS_W-1:0]     q_loss_sat;

  // A sample is dropped whole once the counter is saturated.
  assign acc_en       = session_q && ok_q && (count_q != '1);
  assign lat_sum_ext  = {1'b0, lat_sum_q} + (SUM_W + 1)'(lat_q);
  assign jit_sum_ext  = {1'b0, jit_sum_q} + (SUM_W + 1)'(jit_q);
  assign loss_sum_ext = {1'b0, loss_sum_q} + (LOSS_SUM_W + 1)'(loss_q);
  assign no_samples   = (count_q == '0);
  assign q_sat16      = (|quotient[SUM_W-1:LAT_W]) ? '1 : quotient[LAT_W-1:0];
  assign q_loss_sat   = (quotient > SUM_W'(LOSS_MAX)) ? LOSS_MAX : quotient[LOSS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_q      <= '0;
      session_q   <= 1'b0;
      spike_q     <= 1'b0;
      alert_q     <= 1'b0;
      lat_sum_q   <= '0;
      jit_sum_q   <= '0;
      loss_sum_q  <= '0;
      count_q     <= '0;
      peak_sess_q <= '0;
      peak_all_q  <= '0;
    end else begin
      if (in_acc) begin
        alert_q <= 1'b0;
      end
      if (sess_start) begin
        session_q   <= 1'b1;
        spike_q     <= 1'b0;
        lat_sum_q   <= '0;
        jit_sum_q   <= '0;
        loss_sum_q  <= '0;
        count_q     <= '0;
        peak_sess_q <= '0;
      end
      // The window always holds at least one bit after a tick.
      if (loss_ld) begin
        loss_q <= quotient[LOSS_W-1:0];
      end
      if (tick_upd) begin
        if (ok_q) begin
          if (lat_q > peak_sess_q) peak_sess_q <= lat_q;
          if (lat_q > peak_all_q) peak_all_q <= lat_q;
        end
        if (acc_en) begin
          lat_sum_q  <= lat_sum_ext[SUM_W] ? '1 : lat_sum_ext[SUM_W-1:0];
          jit_sum_q  <= jit_sum_ext[SUM_W] ? '1 : jit_sum_ext[SUM_W-1:0];
          loss_sum_q <= loss_sum_ext[LOSS_SUM_W] ? '1 : loss_sum_ext[LOSS_SUM_W-1:0];
          count_q    <= count_q + 1'b1;
        end
        // Hysteresis: rise above the high mark, fall below the low mark.
        if (session_q && ok_q) begin
          if (lat_q > spike_high_q && !spike_q) begin
            spike_q <= 1'b1;
            alert_q <= 1'b1;
          end else if (lat_q < spike_low_q && spike_q) begin
            spike_q <= 1'b0;
          end
        end
      end
      if (avg_loss_ld) begin
        session_q <= 1'b0;
      end
    end
  end

  // Session means, forced to zero when the session saw no samples.
  logic [LAT_W-1:0]  avg_lat_q, avg_jit_q;
  logic [LOSS_W-1:0] avg_loss_q;

  always_ff @(posedge clk_i) begin
    if (avg_lat_ld) begin
      avg_lat_q <= no_samples ? '0 : q_sat16;
    end
    if (avg_jit_ld) begin
      avg_jit_q <= no_samples ? '0 : q_sat16;
    end
    if (avg_loss_ld) begin
      avg_loss_q <= no_samples ? '0 : q_loss_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It holds one result and frees the sequencer for the next
  // item while the result waits to be taken.
  // ---------------------------------------------------------------------------
  logic is_tick, is_end;

  assign is_tick = (kind_q == KIND_TICK);
  assign is_end  = (kind_q == KIND_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      latency_valid_o <= is_tick && ok_q;
      latency_out_o   <= (is_tick && ok_q) ? lat_q : '0;
      loss_level_o    <= loss_q;
      spike_alert_o   <= alert_q;
      spike_on_o      <= spike_q;
      in_session_o    <= session_q;
      session_done_o  <= is_end;
      avg_latency_o   <= is_end ? avg_lat_q : '0;
      avg_jitter_o    <= is_end ? avg_jit_q : '0;
      avg_loss_o      <= is_end ? avg_loss_q : '0;
      session_peak_o  <= peak_sess_q;
      overall_peak_o  <= peak_all_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `LQM_ASSERT_SAME(a_total_le_fill, clk_i, rst_ni, 1'b1, win_total_q <= win_fill_q, "loss total exceeds window fill")
  `LQM_ASSERT_SAME(a_loss_range, clk_i, rst_ni, 1'b1, loss_q <= LOSS_MAX, "windowed loss out of range")
  `LQM_ASSERT_SAME(a_div_free, clk_i, rst_ni, div_start, !div_sts.busy, "divider started while busy")
  `LQM_ASSERT_NEXT(a_alert_state, clk_i, rst_ni, out_ld && alert_q, spike_on_o && in_session_o, "alert without an active spike in session")

endmodule

### tb/sv/lqm_report_checker.sv
module lqm_report_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [lqm_pkg::KIND_W-1:0]     kind_i,
  input  logic                           ping_ok_i,
  input  logic [lqm_pkg::LAT_W-1:0]      latency_i,
  input  logic [lqm_pkg::LAT_W-1:0]      jitter_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           latency_valid_i,
  input  logic [lqm_pkg::LAT_W-1:0]      latency_out_i,
  input  logic [lqm_pkg::LOSS_W-1:0]     loss_level_i,
  input  logic                           spike_alert_i,
  input  logic                           spike_on_i,
  input  logic                           in_session_i,
  input  logic                           session_done_i,
  input  logic [lqm_pkg::LAT_W-1:0]      avg_latency_i,
  input  logic [lqm_pkg::LAT_W-1:0]      avg_jitter_i,
  input  logic [lqm_pkg::LOSS_W-1:0]     avg_loss_i,
  input  logic [lqm_pkg::LAT_W-1:0]      session_peak_i,
  input  logic [lqm_pkg::LAT_W-1:0]      overall_peak_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lqm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lqm_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [lqm_pkg::APB_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int                             fail_count_o,
  output int                             pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lqm_pkg::*;

  localparam logic [63:0] ACC_MAX      = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] LOSS_ACC_MAX = (64'd1 << LOSS_SUM_W) - 1;
  localparam logic [63:0] SAMPLES_MAX  = (64'd1 << LQM_SAMPLE_COUNT_BITS) - 1;

  typedef struct {
    logic              lat_valid;
    logic [LAT_W-1:0]  lat_out;
    logic [LOSS_W-1:0] loss;
    logic              alert;
    logic              spike;
    logic              sess;
    logic              done;
    logic [LAT_W-1:0]  avg_lat;
    logic [LAT_W-1:0]  avg_jit;
    logic [LOSS_W-1:0] avg_loss;
    logic [LAT_W-1:0]  peak_sess;
    logic [LAT_W-1:0]  peak_all;
  } link_report_t;

  link_report_t expected_reports[$];

  logic [LAT_W-1:0] cfg_high;
  logic [LAT_W-1:0] cfg_low;
  bit               loss_hist[LQM_LOSS_WINDOW];
  int unsigned      hist_pos;
  int unsigned      hist_fill;
  int unsigned      hist_lost;
  bit               session_open;
  bit               spike_flag;
  logic [63:0]      lat_acc;
  logic [63:0]      jit_acc;
  logic [63:0]      loss_acc;
  logic [63:0]      samples;
  logic [LAT_W-1:0] peak_session;
  logic [LAT_W-1:0] peak_overall;

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] lim);
    logic [63:0] s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic logic [LOSS_W-1:0] window_loss();
    if (hist_fill == 0) return '0;
    return LOSS_W'((64'(hist_lost) * LOSS_SCALE) / hist_fill);
  endfunction

  function automatic logic [63:0] mean_clamped(logic [63:0] acc, logic [63:0] lim);
    logic [63:0] q;
    q = acc / samples;
    return (q > lim) ? lim : q;
  endfunction

  task automatic clear_model();
    cfg_high = SPIKE_HIGH_RST;
    cfg_low  = SPIKE_LOW_RST;
    foreach (loss_hist[i]) loss_hist[i] = 1'b0;
    hist_pos     = 0;
    hist_fill    = 0;
    hist_lost    = 0;
    session_open = 1'b0;
    spike_flag   = 1'b0;
    lat_acc      = '0;
    jit_acc      = '0;
    loss_acc     = '0;
    samples      = '0;
    peak_session = '0;
    peak_overall = '0;
    expected_reports.delete();
    fail_count_o = 0;
  endtask

  // Works out the result of one accepted input item and queues it.
  task automatic predict_report();
    link_report_t r;
    r = '{default: '0};
    case (kind_i)
      KIND_TICK: begin
        if (hist_fill >= LQM_LOSS_WINDOW) hist_lost -= loss_hist[hist_pos];
        else hist_fill++;
        loss_hist[hist_pos] = !ping_ok_i;
        hist_lost += ping_ok_i ? 0 : 1;
        hist_pos = (hist_pos + 1) % LQM_LOSS_WINDOW;
        if (ping_ok_i) begin
          if (latency_i > peak_session) peak_session = latency_i;
          if (latency_i > peak_overall) peak_overall = latency_i;
        end
        // A sample that would overflow the counter is dropped as a whole.
        if (session_open && ping_ok_i && samples < SAMPLES_MAX) begin
          lat_acc  = add_clamped(lat_acc, 64'(latency_i), ACC_MAX);
          jit_acc  = add_clamped(jit_acc, 64'(jitter_i), ACC_MAX);
          loss_acc = add_clamped(loss_acc, 64'(window_loss()), LOSS_ACC_MAX);
          samples++;
        end
        if (session_open && ping_ok_i) begin
          if (latency_i > cfg_high && !spike_flag) begin
            spike_flag = 1'b1;
            r.alert    = 1'b1;
          end else if (latency_i < cfg_low && spike_flag) begin
            spike_flag = 1'b0;
          end
        end
        r.lat_valid = ping_ok_i;
        r.lat_out   = ping_ok_i ? latency_i : '0;
      end
      KIND_START: begin
        session_open = 1'b1;
        lat_acc      = '0;
        jit_acc      = '0;
        loss_acc     = '0;
        samples      = '0;
        peak_session = '0;
        spike_flag   = 1'b0;
      end
      KIND_END: begin
        if (samples != 0) begin
          r.avg_lat  = LAT_W'(mean_clamped(lat_acc, 64'hFFFF));
          r.avg_jit  = LAT_W'(mean_clamped(jit_acc, 64'hFFFF));
          r.avg_loss = LOSS_W'(mean_clamped(loss_acc, 64'(LOSS_MAX)));
        end
        r.done       = 1'b1;
        session_open = 1'b0;
      end
      default: begin
      end
    endcase
    r.loss      = window_loss();
    r.spike     = spike_flag;
    r.sess      = session_open;
    r.peak_sess = peak_session;
    r.peak_all  = peak_overall;
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic compare_field(string field, logic [APB_DATA_W-1:0] want,
                               logic [APB_DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_report(link_report_t want);
    compare_field("latency_valid", APB_DATA_W'(want.lat_valid),
                  APB_DATA_W'(latency_valid_i));
    compare_field("latency_out", APB_DATA_W'(want.lat_out), APB_DATA_W'(latency_out_i));
    compare_field("loss_level", APB_DATA_W'(want.loss), APB_DATA_W'(loss_level_i));
    compare_field("spike_alert", APB_DATA_W'(want.alert), APB_DATA_W'(spike_alert_i));
    compare_field("spike_on", APB_DATA_W'(want.spike), APB_DATA_W'(spike_on_i));
    compare_field("in_session", APB_DATA_W'(want.sess), APB_DATA_W'(in_session_i));
    compare_field("session_done", APB_DATA_W'(want.done), APB_DATA_W'(session_done_i));
    compare_field("avg_latency", APB_DATA_W'(want.avg_lat), APB_DATA_W'(avg_latency_i));
    compare_field("avg_jitter", APB_DATA_W'(want.avg_jit), APB_DATA_W'(avg_jitter_i));
    compare_field("avg_loss", APB_DATA_W'(want.avg_loss), APB_DATA_W'(avg_loss_i));
    compare_field("session_peak", APB_DATA_W'(want.peak_sess),
                  APB_DATA_W'(session_peak_i));
    compare_field("overall_peak", APB_DATA_W'(want.peak_all),
                  APB_DATA_W'(overall_peak_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result item with no expectation pending");
          fail_count_o++;
        end else begin
          check_report(expected_reports.pop_front());
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[APB_ADDR_W-1:2] == REG_SPIKE_LOW) cfg_low = pwdata[LAT_W-1:0];
          else cfg_high = pwdata[LAT_W-1:0];
        end else begin
          compare_field("prdata",
                        APB_DATA_W'((paddr[APB_ADDR_W-1:2] == REG_SPIKE_LOW) ?
                                    cfg_low : cfg_high),
                        prdata);
        end
      end
      if (in_valid_i && in_ready_i) predict_report();
    end
    pending_count_o = expected_reports.size();
  end

endmodule

### tb/sv/link_quality_monitor_top_tb.sv
module link_quality_monitor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lqm_pkg::*;

  // The kind field is two bits wide, so one code is left undefined. The block
  // must answer it with a plain status result and change nothing.
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  // The slowest item is a session end, with its three divider passes. Allow for it,
  // the longest sender gap and the long receiver hold-off, then leave a wide margin.
  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned DRAIN_CYCLES    = 150;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned ITEMS_PER_PHASE = 95;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [KIND_W-1:0]     kind_i      = KIND_TICK;
  logic                  ping_ok_i   = 1'b0;
  logic [LAT_W-1:0]      latency_i   = '0;
  logic [LAT_W-1:0]      jitter_i    = '0;
  logic                  out_ready_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  latency_valid_o;
  logic [LAT_W-1:0]      latency_out_o;
  logic [LOSS_W-1:0]     loss_level_o;
  logic                  spike_alert_o;
  logic                  spike_on_o;
  logic                  in_session_o;
  logic                  session_done_o;
  logic [LAT_W-1:0]      avg_latency_o;
  logic [LAT_W-1:0]      avg_jitter_o;
  logic [LOSS_W-1:0]     avg_loss_o;
  logic [LAT_W-1:0]      session_peak_o;
  logic [LAT_W-1:0]      overall_peak_o;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Current idle chances of the two sides, in percent: per item for the sender, per cycle for the receiver.
  int               tx_idle_pct   = 0;
  int               rx_stall_pct  = 0;
  // The main process asks for a receiver hold-off by raising this count.
  int               holds_asked   = 0;
  int               items_sent    = 0;
  int               idle_cycles   = 0;
  int               fail_count;
  int               pending_count;
  // Thresholds as last written, used to aim latencies at the hysteresis band.
  logic [LAT_W-1:0] thr_high      = SPIKE_HIGH_RST;
  logic [LAT_W-1:0] thr_low       = SPIKE_LOW_RST;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  link_quality_monitor_top dut (.*);

  lqm_report_checker report_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .kind_i          (kind_i),
    .ping_ok_i       (ping_ok_i),
    .latency_i       (latency_i),
    .jitter_i        (jitter_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .latency_valid_i (latency_valid_o),
    .latency_out_i   (latency_out_o),
    .loss_level_i    (loss_level_o),
    .spike_alert_i   (spike_alert_o),
    .spike_on_i      (spike_on_o),
    .in_session_i    (in_session_o),
    .session_done_i  (session_done_o),
    .avg_latency_i   (avg_latency_o),
    .avg_jitter_i    (avg_jitter_o),
    .avg_loss_i      (avg_loss_o),
    .session_peak_i  (session_peak_o),
    .overall_peak_i  (overall_peak_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // The receiver changes its ready at the falling edge. When a hold-off has
  // been asked for, it keeps ready low for a long stretch, counting the cycles
  // here, so that the block fills up while the sender keeps offering items.
  initial begin
    int holds_served;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (holds_asked > holds_served) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_served++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // The watchdog ends the run when nothing has moved on any port for too long.
  // This also catches results that never arrive.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("link_quality_monitor_top verification failed");
      $finish;
    end
  end

  // Offers one item, starting and ending at a falling edge. Valid is only
  // dropped when the sender decides to idle before this item; back-to-back
  // items keep it high and just change the payload.
  task automatic send_item(logic [KIND_W-1:0] kind, logic ok, logic [LAT_W-1:0] lat,
                           logic [LAT_W-1:0] jit);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1) ? $urandom_range(10, 120) : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    ping_ok_i  <= ok;
    latency_i  <= lat;
    jitter_i   <= jit;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Stops offering and waits until every queued expectation has been met.
  // Every item yields a result, so the block is idle once this returns.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk_i);
  endtask

  // One APB transfer: a setup cycle, then an access cycle that completes on
  // pready. One spare cycle follows so that back-to-back calls never assign
  // psel twice in the same time step.
  task automatic apb_transfer(logic write, logic idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Writes both thresholds while the block is idle, then reads them back.
  // The checker follows the writes on the port and checks the reads.
  task automatic set_thresholds(logic [LAT_W-1:0] high, logic [LAT_W-1:0] low);
    drain_results();
    apb_transfer(1'b1, REG_SPIKE_HIGH, APB_DATA_W'(high));
    apb_transfer(1'b1, REG_SPIKE_LOW, APB_DATA_W'(low));
    apb_transfer(1'b0, REG_SPIKE_HIGH, '0);
    apb_transfer(1'b0, REG_SPIKE_LOW, '0);
    thr_high = high;
    thr_low  = low;
  endtask

  // Most latencies land close to one of the thresholds so that the spike
  // flag rises and falls often; the rest are extremes or fully random.
  function automatic logic [LAT_W-1:0] pick_latency();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(1) ? {LAT_W{1'b1}} : {LAT_W{1'b0}};
    if (r < 25) return LAT_W'($urandom);
    v = $urandom_range(1) ? int'(thr_high) : int'(thr_low);
    v = v + int'($urandom_range(128)) - 64;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return LAT_W'(v);
  endfunction

  function automatic logic [LAT_W-1:0] pick_jitter();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1) ? {LAT_W{1'b1}} : {LAT_W{1'b0}};
    if (r < 30) return LAT_W'($urandom);
    return LAT_W'($urandom_range(500));
  endfunction

  task automatic send_tick(int loss_pct);
    send_item(KIND_TICK, $urandom_range(99) >= loss_pct, pick_latency(), pick_jitter());
  endtask

  // A well-formed session: start, a run of ticks, end. Most sessions are
  // short; some run long enough to wrap the 60-entry loss window. The unused
  // fields of start and end items carry random values.
  task automatic run_session();
    int ticks;
    int loss_pct;
    case ($urandom_range(3))
      0: loss_pct = 0;
      1: loss_pct = 5;
      2: loss_pct = 40;
      default: loss_pct = 100;
    endcase
    ticks = ($urandom_range(4) == 0) ? $urandom_range(40, 90) : $urandom_range(20);
    send_item(KIND_START, 1'($urandom_range(1)), LAT_W'($urandom), LAT_W'($urandom));
    repeat (ticks) send_tick(loss_pct);
    send_item(KIND_END, 1'($urandom_range(1)), LAT_W'($urandom), LAT_W'($urandom));
  endtask

  // Broken sequences: ticks outside a session, stray ends, repeated starts
  // and the undefined kind, in random order.
  task automatic run_noise();
    repeat ($urandom_range(1, 3)) begin
      send_item(KIND_W'($urandom_range(3)), 1'($urandom_range(1)), pick_latency(),
                pick_jitter());
    end
  endtask

  // One phase of random traffic under a single threshold setting and a
  // single idling pattern. A phase may ask for the long receiver hold-off
  // or for a sender pause that waits for every result.
  task automatic run_phase(logic [LAT_W-1:0] high, logic [LAT_W-1:0] low, int tx_pct,
                           int rx_pct, bit want_hold, bit want_pause);
    int first_item;
    set_thresholds(high, low);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    first_item   = items_sent;
    while (items_sent - first_item < ITEMS_PER_PHASE) begin
      if ($urandom_range(9) < 8) run_session();
      else run_noise();
      if (items_sent - first_item > ITEMS_PER_PHASE / 3) begin
        if (want_hold) begin
          holds_asked++;
          want_hold = 1'b0;
        end
        if (want_pause) begin
          drain_results();
          want_pause = 1'b0;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items under the reset thresholds (spike above 1200, clear
    // below 800), with neither side idling.
    // A session end before any session reports zero means.
    send_item(KIND_END, 1'b0, '0, '0);
    send_item(KIND_TICK, 1'b1, '0, '0);
    // A failed probe with all-ones fields must read as absent latency.
    send_item(KIND_TICK, 1'b0, '1, '1);
    send_item(KIND_UNKNOWN, 1'b1, '1, '1);
    send_item(KIND_START, 1'b0, '0, '0);
    // Just above the high threshold raises the flag and the alert.
    send_item(KIND_TICK, 1'b1, 16'd1201, 16'd7);
    send_item(KIND_TICK, 1'b1, 16'd1200, 16'd9);
    // Already in a spike: no second alert.
    send_item(KIND_TICK, 1'b1, 16'd1300, 16'd11);
    // Failed probes leave the spike flag alone.
    send_item(KIND_TICK, 1'b0, '0, '0);
    send_item(KIND_TICK, 1'b1, 16'd799, 16'd3);
    send_item(KIND_TICK, 1'b1, 16'd800, '0);
    send_item(KIND_TICK, 1'b1, '1, '1);
    send_item(KIND_UNKNOWN, 1'b0, '0, '0);
    // A start during a session restarts it and clears the spike and peak.
    send_item(KIND_START, 1'b1, '1, '1);
    send_item(KIND_TICK, 1'b1, '0, '0);
    send_item(KIND_TICK, 1'b1, 16'd1500, 16'd100);
    send_item(KIND_END, 1'b0, '0, '0);
    // A second end reports the same means from the kept sums.
    send_item(KIND_END, 1'b0, '0, '0);
    // Outside a session the peaks still move but the spike flag does not.
    send_item(KIND_TICK, 1'b1, 16'd20000, 16'd5);
    send_item(KIND_TICK, 1'b1, '0, '0);
    // An empty session has zero means.
    send_item(KIND_START, 1'b0, '0, '0);
    send_item(KIND_END, 1'b0, '0, '0);

    // Random phases, including the threshold extremes and an inverted band.
    run_phase(16'd300, 16'd200, 0, 0, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 47, 0, 1'b0, 1'b1);
    run_phase(16'd0, 16'd0, 0, 47, 1'b0, 1'b0);
    run_phase(16'd0, 16'hFFFF, 34, 34, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'd0, 0, 0, 1'b0, 1'b0);
    begin
      logic [LAT_W-1:0] high;
      high = LAT_W'($urandom_range(500, 3000));
      run_phase(high, LAT_W'($urandom_range(high)), 34, 34, 1'b0, 1'b0);
    end

    // Let any stray result show up before the verdict.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("link_quality_monitor_top verification clean");
    end else begin
      $display("link_quality_monitor_top verification failed");
    end
    $finish;
  end

endmodule
